### design/vgfc_pkg.sv
// shared types, constants and codes of the voxel grid face culler
package vgfc_pkg;

	localparam int MAX_DIM     = 32;
	localparam int MAX_CHUNKS  = 512;
	localparam int DIM_W       = $clog2(MAX_DIM);
	localparam int SIZE_W      = DIM_W + 1;
	localparam int VOX_DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int VOX_AW      = $clog2(VOX_DEPTH);
	localparam int CHUNK_AW    = $clog2(MAX_CHUNKS);
	localparam int LG_W        = 3;
	localparam int LG_MIN      = 2;
	localparam int LG_MAX      = 4;
	localparam int NCH_W       = $clog2(MAX_DIM >> LG_MIN) + 1;
	localparam int FACE_COUNT  = 6;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	// register indexes
	localparam logic [1:0] CFG_SIZE_X     = 2'd0;
	localparam logic [1:0] CFG_SIZE_Y     = 2'd1;
	localparam logic [1:0] CFG_SIZE_Z     = 2'd2;
	localparam logic [1:0] CFG_CHUNK_LOG2 = 2'd3;

	// request modes
	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_READ  = 3'd1;
	localparam logic [2:0] MODE_FACES = 3'd2;
	localparam logic [2:0] MODE_QUERY = 3'd3;
	localparam logic [2:0] MODE_CLEAR = 3'd4;
	localparam logic [2:0] MODE_MARK  = 3'd5;

	// response kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_FACE  = 2'd1;
	localparam logic [1:0] KIND_DIRTY = 2'd2;

	// faces
	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [7:0]         material;
		logic [8:0]         chunk;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] read_material;
		logic [2:0] face;
		logic       dirty;
		logic       last;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_READ,
		OP_FACES,
		OP_QUERY,
		OP_CLEAR,
		OP_MARK
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [VOX_AW-1:0]     vidx;
		logic                  inb;
		logic [FACE_COUNT-1:0] nb_in;
		logic [CHUNK_AW-1:0]   cidx;
		logic                  cvalid;
		logic [7:0]            material;
	} cmd_t;

	typedef struct packed {
		logic [SIZE_W-1:0]       sx;
		logic [SIZE_W-1:0]       sy;
		logic [SIZE_W-1:0]       sz;
		logic [LG_W-1:0]         lg;
		logic [NCH_W-1:0]        nx;
		logic [2*DIM_W:0]        sxy;
		logic [2*NCH_W-2:0]      nxy;
		logic [CHUNK_AW:0]       nchunks;
	} geom_t;

	typedef struct packed {
		logic cfg_busy;
		logic init_busy;
	} hold_t;

endpackage

### design/vgfc_cfg.sv
// configuration registers and derived grid geometry
module vgfc_cfg import vgfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	output geom_t             geom,
	output logic              busy
);

	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [LG_W-1:0]   chunk_log2_q;
	logic [1:0]        hold_q;
	geom_t             geom_q;
	logic [NCH_W-1:0]  ny_q, nz_q;

	logic [SIZE_W-1:0] sx_e, sy_e, sz_e;
	logic [LG_W-1:0]   lg_e;
	logic [NCH_W-1:0]  nx_e, ny_e, nz_e;

	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s == '0)
			r = SIZE_W'(1);
		else if (s > SIZE_W'(MAX_DIM))
			r = SIZE_W'(MAX_DIM);
		return r;
	endfunction

	function automatic logic [NCH_W-1:0] chunks_along(input logic [SIZE_W-1:0] s,
			input logic [LG_W-1:0] lg);
		logic [SIZE_W:0] t;
		t = (SIZE_W+1)'(s) + (((SIZE_W+1)'(1) << lg) - (SIZE_W+1)'(1));
		return NCH_W'(t >> lg);
	endfunction

	always_comb begin
		sx_e = sat_size(size_x_q);
		sy_e = sat_size(size_y_q);
		sz_e = sat_size(size_z_q);
		lg_e = chunk_log2_q;
		if (chunk_log2_q < LG_W'(LG_MIN))
			lg_e = LG_W'(LG_MIN);
		else if (chunk_log2_q > LG_W'(LG_MAX))
			lg_e = LG_W'(LG_MAX);
		nx_e = chunks_along(sx_e, lg_e);
		ny_e = chunks_along(sy_e, lg_e);
		nz_e = chunks_along(sz_e, lg_e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q     <= SIZE_W'(MAX_DIM);
			size_y_q     <= SIZE_W'(MAX_DIM);
			size_z_q     <= SIZE_W'(MAX_DIM);
			chunk_log2_q <= LG_W'(3);
			hold_q       <= '0;
		end else begin
			if (cfg_we) begin
				hold_q <= 2'd3;
				case (cfg_index)
					CFG_SIZE_X:     size_x_q     <= cfg_data;
					CFG_SIZE_Y:     size_y_q     <= cfg_data;
					CFG_SIZE_Z:     size_z_q     <= cfg_data;
					CFG_CHUNK_LOG2: chunk_log2_q <= cfg_data[LG_W-1:0];
					default: ;
				endcase
			end else if (hold_q != '0) begin
				hold_q <= hold_q - 2'd1;
			end
		end
	end

	// derived geometry is registered in turn: sizes and chunk counts, then sxy and nxy, then nchunks
	always_ff @(posedge clk) begin
		geom_q.sx      <= sx_e;
		geom_q.sy      <= sy_e;
		geom_q.sz      <= sz_e;
		geom_q.lg      <= lg_e;
		geom_q.nx      <= nx_e;
		ny_q           <= ny_e;
		nz_q           <= nz_e;
		geom_q.sxy     <= (2*DIM_W+1)'(geom_q.sx) * (2*DIM_W+1)'(geom_q.sy);
		geom_q.nxy     <= (2*NCH_W-1)'(geom_q.nx) * (2*NCH_W-1)'(ny_q);
		geom_q.nchunks <= (CHUNK_AW+1)'(geom_q.nxy) * (CHUNK_AW+1)'(nz_q);
	end

	assign geom = geom_q;
	assign busy = cfg_we || (hold_q != '0);

endmodule

### design/vgfc_front.sv
// request intake, bounds checks, address and chunk index work
module vgfc_front import vgfc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  logic  req_valid,
	output logic  req_stall,
	input  geom_t geom,
	input  hold_t hold,
	output logic  push,
	output cmd_t  push_cmd,
	input  logic  full
);

	req_t req_s1;
	logic vld_s1;

	logic              xin, yin, zin, in_grid;
	logic [DIM_W-1:0]  x5, y5, z5;
	logic [NCH_W-2:0]  cx, cy, cz;
	logic [VOX_AW:0]   vidx_w;
	logic [CHUNK_AW:0] cidx_w;
	logic              keep, advance, accept;
	cmd_t              cmd;

	always_comb begin
		xin = !req_s1.pos_x[15] && (req_s1.pos_x[14:0] < 15'(geom.sx));
		yin = !req_s1.pos_y[15] && (req_s1.pos_y[14:0] < 15'(geom.sy));
		zin = !req_s1.pos_z[15] && (req_s1.pos_z[14:0] < 15'(geom.sz));
		in_grid = xin && yin && zin;
		x5 = req_s1.pos_x[DIM_W-1:0];
		y5 = req_s1.pos_y[DIM_W-1:0];
		z5 = req_s1.pos_z[DIM_W-1:0];

		vidx_w = (VOX_AW+1)'(z5) * (VOX_AW+1)'(geom.sxy)
			+ (VOX_AW+1)'(y5) * (VOX_AW+1)'(geom.sx) + (VOX_AW+1)'(x5);

		cx = (NCH_W-1)'(x5 >> geom.lg);
		cy = (NCH_W-1)'(y5 >> geom.lg);
		cz = (NCH_W-1)'(z5 >> geom.lg);
		cidx_w = (CHUNK_AW+1)'(cz) * (CHUNK_AW+1)'(geom.nxy)
			+ (CHUNK_AW+1)'(cy) * (CHUNK_AW+1)'(geom.nx) + (CHUNK_AW+1)'(cx);

		cmd = '0;
		cmd.vidx = vidx_w[VOX_AW-1:0];
		cmd.inb = in_grid;
		cmd.material = req_s1.material;
		cmd.nb_in[FACE_PX] = (SIZE_W'(x5) + SIZE_W'(1)) < geom.sx;
		cmd.nb_in[FACE_NX] = x5 != '0;
		cmd.nb_in[FACE_PY] = (SIZE_W'(y5) + SIZE_W'(1)) < geom.sy;
		cmd.nb_in[FACE_NY] = y5 != '0;
		cmd.nb_in[FACE_PZ] = (SIZE_W'(z5) + SIZE_W'(1)) < geom.sz;
		cmd.nb_in[FACE_NZ] = z5 != '0;
		cmd.cidx = cidx_w[CHUNK_AW-1:0];
		cmd.cvalid = cidx_w < geom.nchunks;
		keep = 1'b0;

		case (req_s1.mode)
			MODE_WRITE: begin
				cmd.op = OP_WRITE;
				keep = in_grid;
			end
			MODE_READ: begin
				cmd.op = OP_READ;
				keep = 1'b1;
			end
			MODE_FACES: begin
				cmd.op = OP_FACES;
				keep = in_grid;
			end
			MODE_QUERY: begin
				cmd.op = OP_QUERY;
				cmd.cidx = req_s1.chunk;
				cmd.cvalid = (CHUNK_AW+1)'(req_s1.chunk) < geom.nchunks;
				keep = 1'b1;
			end
			MODE_CLEAR: begin
				cmd.op = OP_CLEAR;
				cmd.cidx = req_s1.chunk;
				cmd.cvalid = (CHUNK_AW+1)'(req_s1.chunk) < geom.nchunks;
				keep = cmd.cvalid;
			end
			MODE_MARK: begin
				cmd.op = OP_MARK;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign advance   = vld_s1 && (!keep || !full);
	assign push      = vld_s1 && keep && !full;
	assign push_cmd  = cmd;
	assign req_stall = hold.cfg_busy || hold.init_busy || (vld_s1 && !advance);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
	end

endmodule

### design/vgfc_fifo.sv
// short command queue between intake and execution
module vgfc_fifo import vgfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t               slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (push && !pop)
				count_q <= count_q + (FIFO_AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (FIFO_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

### design/vgfc_back.sv
// command execution: voxel and dirty memories, face scan, response register
module vgfc_back import vgfc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  head,
	input  logic  empty,
	output logic  pop,
	input  geom_t geom,
	output rsp_t  rsp,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output logic  init_busy
);

	typedef enum logic [6:0] {
		ST_INIT = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_RD   = 7'b0000100,
		ST_DQ   = 7'b0001000,
		ST_FC   = 7'b0010000,
		ST_FE   = 7'b0100000,
		ST_SWP  = 7'b1000000
	} st_t;

	logic [7:0] vmem [VOX_DEPTH];
	logic       dmem [MAX_CHUNKS];

	st_t                   state_q, state_nx;
	logic [VOX_AW-1:0]     cnt_q, cnt_nx;
	logic [2:0]            fstep_q, fstep_nx;
	logic [FACE_COUNT-1:0] mask_q, mask_nx, rest;
	cmd_t                  cmd_q;
	logic [7:0]            vrd_q;
	logic                  drd_q;
	rsp_t                  rsp_q, rsp_nx;
	logic                  rsp_valid_q;

	logic                v_we, v_re, d_we, d_re, d_wdata, emit, out_free, cmd_ld, exposed;
	logic [VOX_AW-1:0]   v_waddr, v_raddr, nb_addr;
	logic [7:0]          v_wdata;
	logic [CHUNK_AW-1:0] d_waddr, d_raddr;
	logic [2:0]          fprev, low;

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		case (fstep_q)
			FACE_PX: nb_addr = cmd_q.vidx + VOX_AW'(1);
			FACE_NX: nb_addr = cmd_q.vidx - VOX_AW'(1);
			FACE_PY: nb_addr = cmd_q.vidx + VOX_AW'(geom.sx);
			FACE_NY: nb_addr = cmd_q.vidx - VOX_AW'(geom.sx);
			FACE_PZ: nb_addr = cmd_q.vidx + VOX_AW'(geom.sxy);
			FACE_NZ: nb_addr = cmd_q.vidx - VOX_AW'(geom.sxy);
			default: nb_addr = cmd_q.vidx;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		cnt_nx   = cnt_q;
		fstep_nx = fstep_q;
		mask_nx  = mask_q;
		pop      = 1'b0;
		cmd_ld   = 1'b0;
		v_we     = 1'b0;
		v_waddr  = head.vidx;
		v_wdata  = head.material;
		v_re     = 1'b0;
		v_raddr  = head.vidx;
		d_we     = 1'b0;
		d_waddr  = head.cidx;
		d_wdata  = 1'b1;
		d_re     = 1'b0;
		d_raddr  = head.cidx;
		emit     = 1'b0;
		rsp_nx   = '0;
		rest     = mask_q;
		low      = '0;
		fprev    = fstep_q - 3'd1;
		exposed  = 1'b0;

		case (state_q)
			ST_INIT: begin
				v_we    = 1'b1;
				v_waddr = cnt_q;
				v_wdata = '0;
				d_we    = 1'b1;
				d_waddr = cnt_q[CHUNK_AW-1:0];
				cnt_nx  = cnt_q + VOX_AW'(1);
				if (cnt_q == VOX_AW'(VOX_DEPTH - 1))
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (!empty) begin
					pop    = 1'b1;
					cmd_ld = 1'b1;
					case (head.op)
						OP_WRITE: begin
							v_we = 1'b1;
							d_we = head.cvalid;
						end
						OP_CLEAR: begin
							d_we    = head.cvalid;
							d_wdata = 1'b0;
						end
						OP_MARK: begin
							cnt_nx   = '0;
							state_nx = ST_SWP;
						end
						OP_READ: begin
							v_re     = head.inb;
							state_nx = ST_RD;
						end
						OP_QUERY: begin
							d_re     = 1'b1;
							state_nx = ST_DQ;
						end
						OP_FACES: begin
							v_re     = 1'b1;
							fstep_nx = '0;
							mask_nx  = '0;
							state_nx = ST_FC;
						end
						default: ;
					endcase
				end
			end
			ST_RD: begin
				if (out_free) begin
					emit = 1'b1;
					rsp_nx.kind = KIND_READ;
					rsp_nx.read_material = cmd_q.inb ? vrd_q : 8'd0;
					rsp_nx.last = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_DQ: begin
				if (out_free) begin
					emit = 1'b1;
					rsp_nx.kind = KIND_DIRTY;
					rsp_nx.dirty = cmd_q.cvalid && drd_q;
					rsp_nx.last = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_FC: begin
				// one voxel read per cycle, the result of the previous read checked alongside
				if (fstep_q == '0) begin
					if (vrd_q == '0) begin
						state_nx = ST_IDLE;
					end else begin
						v_re     = cmd_q.nb_in[fstep_q];
						v_raddr  = nb_addr;
						fstep_nx = fstep_q + 3'd1;
					end
				end else begin
					exposed = !cmd_q.nb_in[fprev] || (vrd_q == '0);
					mask_nx[fprev] = exposed;
					if (fstep_q == 3'(FACE_COUNT)) begin
						state_nx = (mask_nx != '0) ? ST_FE : ST_IDLE;
					end else begin
						v_re     = cmd_q.nb_in[fstep_q];
						v_raddr  = nb_addr;
						fstep_nx = fstep_q + 3'd1;
					end
				end
			end
			ST_FE: begin
				for (int f = FACE_COUNT - 1; f >= 0; f--) begin
					if (mask_q[f])
						low = 3'(f);
				end
				rest[low] = 1'b0;
				if (out_free) begin
					emit = 1'b1;
					rsp_nx.kind = KIND_FACE;
					rsp_nx.face = low;
					rsp_nx.last = rest == '0;
					mask_nx = rest;
					if (rest == '0)
						state_nx = ST_IDLE;
				end
			end
			ST_SWP: begin
				d_we    = 1'b1;
				d_waddr = cnt_q[CHUNK_AW-1:0];
				cnt_nx  = cnt_q + VOX_AW'(1);
				if (cnt_q[CHUNK_AW-1:0] == CHUNK_AW'(MAX_CHUNKS - 1))
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			fstep_q     <= '0;
			mask_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
			fstep_q <= fstep_nx;
			mask_q  <= mask_nx;
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ld)
			cmd_q <= head;
		if (emit)
			rsp_q <= rsp_nx;
	end

	// voxel memory
	always_ff @(posedge clk) begin
		if (v_we)
			vmem[v_waddr] <= v_wdata;
		if (v_re)
			vrd_q <= vmem[v_raddr];
	end

	// dirty memory
	always_ff @(posedge clk) begin
		if (d_we)
			dmem[d_waddr] <= d_wdata;
		if (d_re)
			drd_q <= dmem[d_raddr];
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;
	assign init_busy = state_q == ST_INIT;

endmodule

### design/voxel_grid_face_culler.sv
// top level of the voxel grid face culler
//
//   channel  signals                      word   direction
//   req      req_valid, req_stall, req    req_t  in, stall driven here
//   rsp      rsp_valid, rsp_stall, rsp    rsp_t  out, stall driven by sink
//   cfg      cfg_we, cfg_index, cfg_data  6 bit  in, no wait
//
// write and dirty clear finish in the idle state; read and dirty query wait for the sink
// faces: neighbour reads on the single voxel memory read port, a word per open face
// mark all dirty: sweeps the 512 entry dirty memory
// after reset req_stall stays high while the voxel memory is cleared
// a register write holds req_stall while the cfg block is busy; rsp_stall holds
// the response register, and a 4 deep command queue keeps intake running until it fills
module voxel_grid_face_culler import vgfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req,
	input  logic              req_valid,
	output logic              req_stall,
	output rsp_t              rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	geom_t geom;
	hold_t hold;
	logic  cfg_busy, init_busy;
	logic  push, full, pop, empty;
	cmd_t  push_cmd, head;

	assign hold.cfg_busy  = cfg_busy;
	assign hold.init_busy = init_busy;

	vgfc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.busy      (cfg_busy)
	);

	vgfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.geom      (geom),
		.hold      (hold),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	vgfc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	vgfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.geom      (geom),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.init_busy (init_busy)
	);

endmodule

### test/voxel_grid_face_culler_checker.sv
`timescale 1ns / 100ps
// checker for the voxel grid face culler: mirrors the grid and dirty bits, predicts and compares words
module voxel_grid_face_culler_checker
	import vgfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req,
	input  logic              req_valid,
	input  logic              req_stall,
	input  rsp_t              rsp,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	output int                mismatches,
	output int                answers_pending
);

	logic [7:0]        voxel_mem [VOX_DEPTH];
	logic              dirty_bits [MAX_CHUNKS];
	logic [SIZE_W-1:0] reg_sx, reg_sy, reg_sz;
	logic [LG_W-1:0]   reg_lg;
	rsp_t              answers_due [$];

	function automatic int span(logic [SIZE_W-1:0] s);
		if (s < 1) return 1;
		if (s > MAX_DIM) return MAX_DIM;
		return s;
	endfunction

	function automatic int chunk_shift();
		if (reg_lg < LG_MIN) return LG_MIN;
		if (reg_lg > LG_MAX) return LG_MAX;
		return reg_lg;
	endfunction

	function automatic int chunks_on(int s);
		return (s + (1 << chunk_shift()) - 1) >> chunk_shift();
	endfunction

	function automatic bit on_grid(int x, int y, int z);
		return x >= 0 && y >= 0 && z >= 0 &&
			x < span(reg_sx) && y < span(reg_sy) && z < span(reg_sz);
	endfunction

	function automatic int cell_of(int x, int y, int z);
		return (z * span(reg_sx) * span(reg_sy) + y * span(reg_sx) + x) % VOX_DEPTH;
	endfunction

	function automatic logic [7:0] voxel_at(int x, int y, int z);
		if (!on_grid(x, y, z)) return '0;
		return voxel_mem[cell_of(x, y, z)];
	endfunction

	function automatic bit chunk_live(int ci);
		int n;
		n = chunks_on(span(reg_sx)) * chunks_on(span(reg_sy)) * chunks_on(span(reg_sz));
		return ci < n && ci < MAX_CHUNKS;
	endfunction

	function automatic void face_offset(input logic [2:0] fc, output int ox, output int oy,
		output int oz);
		ox = 0;
		oy = 0;
		oz = 0;
		case (fc)
			FACE_PX: ox = 1;
			FACE_NX: ox = -1;
			FACE_PY: oy = 1;
			FACE_NY: oy = -1;
			FACE_PZ: oz = 1;
			default: oz = -1;
		endcase
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic answer_request(req_t w);
		int         x, y, z, lg, nx, ny, ci, ox, oy, oz;
		rsp_t       a;
		logic [2:0] open_faces [$];
		x = $signed(w.pos_x);
		y = $signed(w.pos_y);
		z = $signed(w.pos_z);
		a = '0;
		a.last = 1'b1;
		case (w.mode)
			MODE_WRITE: begin
				if (on_grid(x, y, z)) begin
					voxel_mem[cell_of(x, y, z)] = w.material;
					lg = chunk_shift();
					nx = chunks_on(span(reg_sx));
					ny = chunks_on(span(reg_sy));
					ci = (z >> lg) * nx * ny + (y >> lg) * nx + (x >> lg);
					if (chunk_live(ci)) dirty_bits[ci] = 1'b1;
				end
			end
			MODE_READ: begin
				a.kind = KIND_READ;
				a.read_material = voxel_at(x, y, z);
				answers_due.insert(answers_due.size(), a);
			end
			MODE_FACES: begin
				if (voxel_at(x, y, z) != 0) begin
					for (logic [2:0] fc = FACE_PX; fc <= FACE_NZ; fc++) begin
						face_offset(fc, ox, oy, oz);
						if (voxel_at(x + ox, y + oy, z + oz) == 0)
							open_faces.insert(open_faces.size(), fc);
					end
					foreach (open_faces[i]) begin
						a = '0;
						a.kind = KIND_FACE;
						a.face = open_faces[i];
						a.last = (i == open_faces.size() - 1);
						answers_due.insert(answers_due.size(), a);
					end
				end
			end
			MODE_QUERY: begin
				a.kind = KIND_DIRTY;
				a.dirty = chunk_live(w.chunk) ? dirty_bits[w.chunk] : 1'b0;
				answers_due.insert(answers_due.size(), a);
			end
			MODE_CLEAR: begin
				if (chunk_live(w.chunk)) dirty_bits[w.chunk] = 1'b0;
			end
			MODE_MARK: begin
				foreach (dirty_bits[i]) dirty_bits[i] = 1'b1;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t due;
		if (!arst_n) begin
			foreach (voxel_mem[i]) voxel_mem[i] = '0;
			foreach (dirty_bits[i]) dirty_bits[i] = 1'b1;
			reg_sx = SIZE_W'(MAX_DIM);
			reg_sy = SIZE_W'(MAX_DIM);
			reg_sz = SIZE_W'(MAX_DIM);
			reg_lg = LG_W'(3);
			answers_due.delete();
			mismatches = 0;
			answers_pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("response word %h with nothing due", rsp));
				end else begin
					due = answers_due.pop_front();
					if (rsp.kind !== due.kind)
						report_mismatch($sformatf("kind %0d, want %0d", rsp.kind, due.kind));
					if (rsp.read_material !== due.read_material)
						report_mismatch($sformatf("read_material %0d, want %0d",
							rsp.read_material, due.read_material));
					if (rsp.face !== due.face)
						report_mismatch($sformatf("face %0d, want %0d", rsp.face, due.face));
					if (rsp.dirty !== due.dirty)
						report_mismatch($sformatf("dirty %0d, want %0d", rsp.dirty, due.dirty));
					if (rsp.last !== due.last)
						report_mismatch($sformatf("last %0d, want %0d", rsp.last, due.last));
				end
			end
			if (req_valid && !req_stall) answer_request(req);
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIZE_X: reg_sx = cfg_data;
					CFG_SIZE_Y: reg_sy = cfg_data;
					CFG_SIZE_Z: reg_sz = cfg_data;
					CFG_CHUNK_LOG2: reg_lg = cfg_data[LG_W-1:0];
					default: ;
				endcase
			end
			answers_pending <= answers_due.size();
		end
	end

endmodule

### test/voxel_grid_face_culler_tb.sv
`timescale 1ns / 100ps
// testbench top for the voxel grid face culler: stimulus, pacing, watchdog and verdict
module voxel_grid_face_culler_tb;
	import vgfc_pkg::*;

	localparam int WATCHDOG_LIMIT   = 150000;
	localparam int SETTLE_CYCLES    = 600;
	localparam int HOLD_CYCLES      = 300;
	localparam int RANDOM_PER_PHASE = 48;
	localparam int PHASES           = 8;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	req_t              req = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	rsp_t              rsp;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;

	int mismatches;
	int answers_pending;
	int grid_x = MAX_DIM, grid_y = MAX_DIM, grid_z = MAX_DIM, chunk_total = 64;
	int base_x = 0, base_y = 0, base_z = 0;
	int burst_left = 0, max_burst = 8, max_gap = 4;
	int hold_requests = 0, hold_served = 0, hold_left = 0;
	int stall_tick = 0, idle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	voxel_grid_face_culler DUT (
		.clk(clk), .arst_n(arst_n),
		.req(req), .req_valid(req_valid), .req_stall(req_stall),
		.rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	voxel_grid_face_culler_checker CHK (
		.clk(clk), .arst_n(arst_n),
		.req(req), .req_valid(req_valid), .req_stall(req_stall),
		.rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .answers_pending(answers_pending)
	);

	// response side: long hold on request, otherwise a rotating stall pattern
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_requests;
		end else begin
			case ((stall_tick / 64) % 4)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= 1'($urandom_range(0, 1));
				2: rsp_stall <= (stall_tick % 4) != 0;
				default: rsp_stall <= $urandom_range(0, 4) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_count <= 0;
		end else if (idle_count >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	function automatic req_t word_of(logic [2:0] m, int x, int y, int z, int mat, int ch);
		req_t w;
		w.mode = m;
		w.pos_x = 16'(x);
		w.pos_y = 16'(y);
		w.pos_z = 16'(z);
		w.material = 8'(mat);
		w.chunk = 9'(ch);
		return w;
	endfunction

	function automatic logic signed [15:0] pick_coord(int size, int base, bit cluster);
		int r;
		r = $urandom_range(0, 99);
		if (cluster) return 16'(base + int'($urandom_range(0, 2)));
		if (r < 60) return 16'($urandom_range(0, size - 1));
		if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return -16'sd1;
				1: return 16'sd0;
				2: return 16'(size - 1);
				default: return 16'(size);
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic req_t random_word();
		req_t w;
		int   r;
		bit   cl;
		r = $urandom_range(0, 99);
		cl = $urandom_range(0, 99) < 60;
		if (r < 34) w.mode = MODE_WRITE;
		else if (r < 50) w.mode = MODE_READ;
		else if (r < 75) w.mode = MODE_FACES;
		else if (r < 85) w.mode = MODE_QUERY;
		else if (r < 93) w.mode = MODE_CLEAR;
		else if (r < 95) w.mode = MODE_MARK;
		else w.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
		w.pos_x = pick_coord(grid_x, base_x, cl);
		w.pos_y = pick_coord(grid_y, base_y, cl);
		w.pos_z = pick_coord(grid_z, base_z, cl);
		r = $urandom_range(0, 99);
		w.material = r < 15 ? 8'd0 : (r < 25 ? 8'd255 : 8'($urandom_range(1, 255)));
		w.chunk = $urandom_range(0, 99) < 70 ? 9'($urandom_range(0, chunk_total)) :
			9'($urandom);
		return w;
	endfunction

	function automatic int fit(int s);
		return s < 1 ? 1 : (s > MAX_DIM ? MAX_DIM : s);
	endfunction

	task automatic send_word(req_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, max_burst);
		end
		req <= w;
		req_valid <= 1'b1;
		burst_left--;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain(int settle);
		req_valid <= 1'b0;
		do @(posedge clk); while (answers_pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_geometry(int sx, int sy, int sz, int lg);
		int e;
		drain(SETTLE_CYCLES);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SIZE_X;
		cfg_data <= SIZE_W'(sx);
		@(posedge clk);
		cfg_index <= CFG_SIZE_Y;
		cfg_data <= SIZE_W'(sy);
		@(posedge clk);
		cfg_index <= CFG_SIZE_Z;
		cfg_data <= SIZE_W'(sz);
		@(posedge clk);
		cfg_index <= CFG_CHUNK_LOG2;
		cfg_data <= SIZE_W'(lg);
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_x = fit(sx);
		grid_y = fit(sy);
		grid_z = fit(sz);
		e = lg % 8;
		e = e < LG_MIN ? LG_MIN : (e > LG_MAX ? LG_MAX : e);
		chunk_total = ((grid_x + (1 << e) - 1) >> e) * ((grid_y + (1 << e) - 1) >> e) *
			((grid_z + (1 << e) - 1) >> e);
	endtask

	initial begin
		req_t w;
		int   n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_word(word_of(MODE_READ, 0, 0, 0, 0, 0));
		send_word(word_of(MODE_WRITE, -32768, 32767, 0, 8'hAA, 0));
		send_word(word_of(MODE_WRITE, 31, 31, 31, 8'hFF, 0));
		send_word(word_of(MODE_READ, 31, 31, 31, 0, 0));
		send_word(word_of(MODE_READ, 32, 31, -1, 0, 0));
		send_word(word_of(MODE_FACES, 31, 31, 31, 0, 0));
		send_word(word_of(MODE_FACES, 0, 0, 0, 0, 0));
		send_word(word_of(MODE_WRITE, 1, 1, 1, 8'h01, 0));
		send_word(word_of(MODE_WRITE, 2, 1, 1, 8'h80, 0));
		send_word(word_of(MODE_WRITE, 0, 1, 1, 8'h40, 0));
		send_word(word_of(MODE_WRITE, 1, 2, 1, 8'h20, 0));
		send_word(word_of(MODE_WRITE, 1, 0, 1, 8'h10, 0));
		send_word(word_of(MODE_WRITE, 1, 1, 2, 8'h08, 0));
		send_word(word_of(MODE_WRITE, 1, 1, 0, 8'h02, 0));
		// enclosed on all six sides
		send_word(word_of(MODE_FACES, 1, 1, 1, 0, 0));
		send_word(word_of(MODE_FACES, 1, 0, 1, 0, 0));
		send_word(word_of(MODE_QUERY, 0, 0, 0, 0, 0));
		send_word(word_of(MODE_CLEAR, 0, 0, 0, 0, 0));
		send_word(word_of(MODE_QUERY, 0, 0, 0, 0, 0));
		send_word(word_of(MODE_QUERY, 0, 0, 0, 0, 64));
		send_word(word_of(MODE_QUERY, 0, 0, 0, 0, 511));
		send_word(word_of(MODE_MARK, 0, 0, 0, 0, 0));
		send_word(word_of(MODE_QUERY, 0, 0, 0, 0, 0));
		send_word(word_of(MODE_SPARE_LO, 1, 1, 1, 0, 0));
		send_word(word_of(MODE_SPARE_HI, 1, 1, 1, 0, 0));

		// sink holds off while words keep coming
		drain(SETTLE_CYCLES);
		hold_requests <= hold_requests + 1;
		max_gap = 0;
		burst_left = 0;
		repeat (24) send_word(word_of(MODE_FACES, 31, 31, 31, 0, 0));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: set_geometry(4, 4, 4, 2);
				2: set_geometry(1, 1, 1, 4);
				3: set_geometry(0, 63, 5, 0);
				4: set_geometry(32, 7, 9, 7);
				5: set_geometry(17, 32, 3, 1);
				6: set_geometry(5, 6, 7, 6'h3B);
				7: set_geometry(32, 32, 32, 3);
				default: ;
			endcase
			case (p % 3)
				0: begin
					max_gap = 0;
					max_burst = 64;
				end
				1: begin
					max_gap = 3;
					max_burst = 6;
				end
				default: begin
					max_gap = 12;
					max_burst = 3;
				end
			endcase
			burst_left = 0;
			base_x = $urandom_range(0, grid_x > 3 ? grid_x - 3 : 0);
			base_y = $urandom_range(0, grid_y > 3 ? grid_y - 3 : 0);
			base_z = $urandom_range(0, grid_z > 3 ? grid_z - 3 : 0);
			n = 0;
			while (n < RANDOM_PER_PHASE) begin
				w = random_word();
				send_word(w);
				if (w.mode <= MODE_MARK) n++;
			end
		end

		drain(SETTLE_CYCLES);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
